### rtl/core/ple_pkg.sv
// shared types, opcodes and status codes for the positional list engine
package ple_pkg;

  // list capacity and derived widths
  localparam int DEPTH       = 64;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = 7;
  localparam int QUEUE_DEPTH = 2;

  // operation codes
  localparam logic [2:0] OP_INS_FRONT = 3'd0;
  localparam logic [2:0] OP_INS_BACK  = 3'd1;
  localparam logic [2:0] OP_DEL_FRONT = 3'd2;
  localparam logic [2:0] OP_DEL_BACK  = 3'd3;
  localparam logic [2:0] OP_INS_AT    = 3'd4;
  localparam logic [2:0] OP_DEL_AT    = 3'd5;
  localparam logic [2:0] OP_DUMP      = 3'd6;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_BADPOS = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  // actions passed from front to back
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_INS  = 2'd1;
  localparam logic [1:0] ACT_DEL  = 2'd2;
  localparam logic [1:0] ACT_DUMP = 2'd3;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] value;
    logic [6:0]         position;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] element;
    logic [6:0]         count;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]         act;
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] value;
    logic [1:0]         status;
    logic [CNT_W-1:0]   count;
  } cmd_t;

endpackage

### rtl/core/ple_front.sv
// front end: accepts operations, checks them against the running count, issues commands
module ple_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ple_pkg::in_item_t in_data,
  output logic              push_valid,
  input  logic              push_full,
  output ple_pkg::cmd_t     push_cmd
);

  logic [ple_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [ple_pkg::CNT_W:0]   count_p1;
  logic [ple_pkg::CNT_W:0]   pos_ext;
  logic [6:0]                pos_m1;
  ple_pkg::cmd_t             cmd;

  assign count_p1 = {1'b0, count_r} + {{ple_pkg::CNT_W{1'b0}}, 1'b1};
  assign pos_ext  = {1'b0, in_data.position};
  assign pos_m1   = in_data.position - 7'd1;

  // classify the operation and work out the new count
  always_comb begin
    cmd        = '0;
    cmd.act    = ple_pkg::ACT_NONE;
    cmd.value  = in_data.value;
    cmd.status = ple_pkg::ST_OK;
    count_nxt  = count_r;
    unique case (in_data.opcode) inside
      ple_pkg::OP_INS_FRONT, ple_pkg::OP_INS_BACK, ple_pkg::OP_INS_AT: begin
        if (count_r >= ple_pkg::CNT_W'(ple_pkg::DEPTH)) begin
          cmd.status = ple_pkg::ST_FULL;
        end else if (in_data.opcode == ple_pkg::OP_INS_FRONT) begin
          cmd.act   = ple_pkg::ACT_INS;
          cmd.idx   = '0;
          count_nxt = count_p1[ple_pkg::CNT_W-1:0];
        end else if (in_data.opcode == ple_pkg::OP_INS_BACK) begin
          cmd.act   = ple_pkg::ACT_INS;
          cmd.idx   = count_r[ple_pkg::IDX_W-1:0];
          count_nxt = count_p1[ple_pkg::CNT_W-1:0];
        end else if (in_data.position == 7'd0 || pos_ext > count_p1) begin
          cmd.status = ple_pkg::ST_BADPOS;
        end else begin
          cmd.act   = ple_pkg::ACT_INS;
          cmd.idx   = pos_m1[ple_pkg::IDX_W-1:0];
          count_nxt = count_p1[ple_pkg::CNT_W-1:0];
        end
      end
      ple_pkg::OP_DEL_FRONT, ple_pkg::OP_DEL_BACK, ple_pkg::OP_DEL_AT: begin
        if (count_r == '0) begin
          cmd.status = ple_pkg::ST_EMPTY;
        end else if (in_data.opcode == ple_pkg::OP_DEL_FRONT) begin
          cmd.act   = ple_pkg::ACT_DEL;
          cmd.idx   = '0;
          count_nxt = count_r - 1'b1;
        end else if (in_data.opcode == ple_pkg::OP_DEL_BACK) begin
          cmd.act   = ple_pkg::ACT_DEL;
          cmd.idx   = ple_pkg::IDX_W'(count_r - 1'b1);
          count_nxt = count_r - 1'b1;
        end else if (in_data.position == 7'd0 || in_data.position > count_r) begin
          cmd.status = ple_pkg::ST_BADPOS;
        end else begin
          cmd.act   = ple_pkg::ACT_DEL;
          cmd.idx   = pos_m1[ple_pkg::IDX_W-1:0];
          count_nxt = count_r - 1'b1;
        end
      end
      ple_pkg::OP_DUMP: begin
        if (count_r == '0) begin
          cmd.status = ple_pkg::ST_EMPTY;
        end else begin
          cmd.act = ple_pkg::ACT_DUMP;
        end
      end
      default: begin
        cmd.act = ple_pkg::ACT_NONE;
      end
    endcase
    cmd.count = count_nxt;
  end

  assign in_stall   = push_full;
  assign push_valid = in_valid;
  assign push_cmd   = cmd;

  // running element count, advanced on each accepted transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (in_valid && !push_full) begin
      count_r <= count_nxt;
    end
  end

endmodule

### rtl/core/ple_queue.sv
// short command queue between front and back
module ple_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_full,
  input  ple_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output ple_pkg::cmd_t pop_cmd
);

  localparam int PTR_W  = (ple_pkg::QUEUE_DEPTH > 1) ? $clog2(ple_pkg::QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(ple_pkg::QUEUE_DEPTH + 1);

  ple_pkg::cmd_t     ent_r [ple_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              do_push, do_pop;

  assign push_full = (fill_r == FILL_W'(ple_pkg::QUEUE_DEPTH));
  assign pop_valid = (fill_r != '0);
  assign pop_cmd   = ent_r[rd_ptr_r];
  assign do_push   = push_valid && !push_full;
  assign do_pop    = pop_valid && pop_ready;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(ple_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(ple_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### rtl/core/ple_back.sv
// back end: shifting cell chain that applies commands and streams results
module ple_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  ple_pkg::cmd_t      pop_cmd,
  output logic               out_valid,
  input  logic               out_stall,
  output ple_pkg::out_item_t out_data
);

  localparam logic [1:0] CELL_HOLD = 2'd0;
  localparam logic [1:0] CELL_INS  = 2'd1;
  localparam logic [1:0] CELL_DEL  = 2'd2;
  localparam logic [1:0] CELL_ROT  = 2'd3;

  logic signed [31:0]        cell_r   [ple_pkg::DEPTH];
  logic signed [31:0]        cell_nxt [ple_pkg::DEPTH];
  logic                      dump_active_r, dump_active_nxt;
  logic [ple_pkg::CNT_W-1:0] dump_idx_r, dump_idx_nxt;
  logic [ple_pkg::CNT_W-1:0] dump_cnt_r, dump_cnt_nxt;
  logic                      out_valid_r, out_valid_nxt;
  ple_pkg::out_item_t        out_r, out_nxt;
  logic                      out_ready, take, step, dump_last;
  logic [1:0]                mode;

  assign out_ready = !out_valid_r || !out_stall;
  assign pop_ready = out_ready && !dump_active_r;
  assign take      = pop_valid && pop_ready;
  assign step      = dump_active_r && out_ready;
  assign dump_last = (dump_idx_r + 1'b1 == dump_cnt_r);

  // chain operation for this cycle
  always_comb begin
    mode = CELL_HOLD;
    if (take && pop_cmd.act == ple_pkg::ACT_INS) begin
      mode = CELL_INS;
    end else if (take && pop_cmd.act == ple_pkg::ACT_DEL) begin
      mode = CELL_DEL;
    end else if (step) begin
      mode = CELL_ROT;
    end
  end

  // per-cell next value from its neighbors, the command value or, in a rotation, cell 0
  for (genvar i = 0; i < ple_pkg::DEPTH; i++) begin : g_cell
    logic signed [31:0] prev_val, next_val;

    if (i == 0) begin : g_first
      assign prev_val = cell_r[0];
    end else begin : g_mid
      assign prev_val = cell_r[i-1];
    end
    if (i == ple_pkg::DEPTH - 1) begin : g_tail
      assign next_val = cell_r[i];
    end else begin : g_body
      assign next_val = cell_r[i+1];
    end

    always_comb begin
      cell_nxt[i] = cell_r[i];
      case (mode)
        CELL_INS: begin
          if (ple_pkg::IDX_W'(i) > pop_cmd.idx) begin
            cell_nxt[i] = prev_val;
          end else if (ple_pkg::IDX_W'(i) == pop_cmd.idx) begin
            cell_nxt[i] = pop_cmd.value;
          end
        end
        CELL_DEL: begin
          if (ple_pkg::IDX_W'(i) >= pop_cmd.idx) begin
            cell_nxt[i] = next_val;
          end
        end
        CELL_ROT: begin
          if (ple_pkg::CNT_W'(i + 1) == dump_cnt_r) begin
            cell_nxt[i] = cell_r[0];
          end else if (ple_pkg::CNT_W'(i + 1) < dump_cnt_r) begin
            cell_nxt[i] = next_val;
          end
        end
        default: begin
          cell_nxt[i] = cell_r[i];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < ple_pkg::DEPTH; k++) begin
      cell_r[k] <= cell_nxt[k];
    end
  end

  // result register and dump sequencing
  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_nxt         = out_r;
    dump_active_nxt = dump_active_r;
    dump_idx_nxt    = dump_idx_r;
    dump_cnt_nxt    = dump_cnt_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (take) begin
      if (pop_cmd.act == ple_pkg::ACT_DUMP) begin
        dump_active_nxt = 1'b1;
        dump_idx_nxt    = '0;
        dump_cnt_nxt    = pop_cmd.count;
      end else begin
        out_valid_nxt   = 1'b1;
        out_nxt.status  = pop_cmd.status;
        out_nxt.element = '0;
        out_nxt.count   = pop_cmd.count;
        out_nxt.last    = 1'b1;
      end
    end
    if (step) begin
      out_valid_nxt   = 1'b1;
      out_nxt.status  = ple_pkg::ST_OK;
      out_nxt.element = cell_r[0];
      out_nxt.count   = dump_cnt_r;
      out_nxt.last    = dump_last;
      dump_idx_nxt    = dump_idx_r + 1'b1;
      if (dump_last) begin
        dump_active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      dump_active_r <= 1'b0;
      dump_idx_r    <= '0;
      dump_cnt_r    <= '0;
    end else begin
      out_valid_r   <= out_valid_nxt;
      dump_active_r <= dump_active_nxt;
      dump_idx_r    <= dump_idx_nxt;
      dump_cnt_r    <= dump_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### rtl/core/positional_list_engine.sv
// top level of the positional list engine: front, command queue and cell chain back end
//
//   channel | ports                          | direction | transfer when
//   --------+--------------------------------+-----------+---------------------
//   input   | in_valid, in_stall, in_data    | in        | in_valid && !in_stall
//   result  | out_valid, out_stall, out_data | out       | out_valid && !out_stall
//
// an operation is checked in the front in the cycle it is accepted and waits in a
// two-entry queue; the cell chain applies an insert or delete by shifting its cells.
// a dump holds the back end until its last element is out, one rotation of the
// chain per element through the single result register.
// synchronous active-low reset empties the list and the queue; cells hold no reset.
// in_stall rises only while the queue is full; out_stall holds the result register.
module positional_list_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ple_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ple_pkg::out_item_t out_data
);

  logic          push_valid, push_full;
  logic          pop_valid, pop_ready;
  ple_pkg::cmd_t push_cmd, pop_cmd;

  ple_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_full  (push_full),
    .push_cmd   (push_cmd)
  );

  ple_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_full  (push_full),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  ple_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### rtl/core/ple_checker.sv
// port-level checks for the positional list engine, bound to the top level
module ple_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input ple_pkg::out_item_t out_data
);

  // a stalled result stays and holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // the count never exceeds the list capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.count <= ple_pkg::CNT_W'(ple_pkg::DEPTH))
    else $error("count above capacity");

  // only dump elements may be followed by more results of the same operation
  a_mid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> out_data.status == ple_pkg::ST_OK)
    else $error("non-final result without ok status");

  // a dump streams its elements back to back at a constant count
  a_dump_stream: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last |=>
      out_valid && out_data.count == $past(out_data.count))
    else $error("dump stream broken");

endmodule

bind positional_list_engine ple_checker u_ple_checker (.*);
